@@ sv/projective_reprojection_error_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the projective reprojection error block
// Concurrent checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_REPROJECTION_ERROR_MACROS_SVH
`define PROJECTIVE_REPROJECTION_ERROR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PRE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define PRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRE_ASSERT(lbl, clk, rst_n, prop)
`define PRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/pre_pkg.sv @@
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types, constants and saturation helpers of the reprojection block.
// ----------------------------------------------------------------------------
package pre_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int ENTRIES         = 12;
    localparam int IDX_W           = 4;
    localparam int FRAC            = 16;
    localparam int ACC_W           = 66;
    localparam int NUM_W           = DATA_W + FRAC;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_PROJ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_DEPTH = 2'd1,
        ST_SAT        = 2'd2
    } t_status;

    // Work item between front and back: a load carries the entry in a0,
    // a projection carries the point in a0..a2.
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] a0;
        logic [DATA_W-1:0] a1;
        logic [DATA_W-1:0] a2;
        logic              pt_sat;
        logic [DATA_W-1:0] obs_x;
        logic [DATA_W-1:0] obs_y;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] rx;
        logic [DATA_W-1:0] ry;
        t_status           status;
    } t_res;

    function automatic int eff_width(input int w);
        int e;
        e = w;
        if (e > DATA_W) e = DATA_W;
        if (e < 16) e = 16;
        return e;
    endfunction

    function automatic logic signed [ACC_W-1:0] sx32(input logic [DATA_W-1:0] v);
        return ACC_W'(signed'(v));
    endfunction

    // Returns {saturated flag, value clipped to eff signed bits}.
    function automatic logic [DATA_W:0] sat_val(input logic signed [ACC_W-1:0] v,
                                                 input int eff);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic [DATA_W:0]         r;
        hi = (signed'(ACC_W'(1)) <<< (eff - 1)) - signed'(ACC_W'(1));
        lo = -hi - signed'(ACC_W'(1));
        if (v > hi) begin
            r = {1'b1, hi[DATA_W-1:0]};
        end else if (v < lo) begin
            r = {1'b1, lo[DATA_W-1:0]};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

@@ sv/pre_queue.sv @@
// ----------------------------------------------------------------------------
// pre_queue
// Small first-in first-out queue of registers.
// ----------------------------------------------------------------------------
`include "projective_reprojection_error_macros.svh"

module pre_queue #(
    parameter int W     = 8,
    parameter int DEPTH = pre_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `PRE_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `PRE_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1)
    `PRE_ASSERT_NEXT(a_count_dn, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(r_count) - 1'b1)

endmodule

@@ sv/pre_front.sv @@
// ----------------------------------------------------------------------------
// pre_front
// Accepts requests, forms saturated sums and drops loads to missing entries.
// ----------------------------------------------------------------------------
module pre_front #(
    parameter int VALUE_WIDTH = pre_pkg::VALUE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_opcode,
    input  logic [pre_pkg::IDX_W-1:0] i_entry_index,
    input  logic [31:0]               i_camera_delta,
    input  logic [31:0]               i_camera_base,
    input  logic [31:0]               i_point_x_delta,
    input  logic [31:0]               i_point_y_delta,
    input  logic [31:0]               i_point_z_delta,
    input  logic [31:0]               i_point_x_base,
    input  logic [31:0]               i_point_y_base,
    input  logic [31:0]               i_point_z_base,
    input  logic [31:0]               i_observed_x,
    input  logic [31:0]               i_observed_y,
    output logic                      o_cmd_push,
    output pre_pkg::t_cmd             o_cmd,
    input  logic                      i_cmd_full
);

    localparam int EffW = pre_pkg::eff_width(VALUE_WIDTH);

    logic          r_valid;
    pre_pkg::t_cmd r_cmd;
    pre_pkg::t_cmd n_cmd;
    logic          accept;
    logic          keep;
    logic [32:0]   s_cam;
    logic [32:0]   s_x;
    logic [32:0]   s_y;
    logic [32:0]   s_z;

    assign full       = r_valid && i_cmd_full;
    assign accept     = push && !full;
    assign o_cmd_push = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        s_cam = pre_pkg::sat_val(pre_pkg::sx32(i_camera_delta)
                                 + pre_pkg::sx32(i_camera_base), EffW);
        s_x   = pre_pkg::sat_val(pre_pkg::sx32(i_point_x_delta)
                                 + pre_pkg::sx32(i_point_x_base), EffW);
        s_y   = pre_pkg::sat_val(pre_pkg::sx32(i_point_y_delta)
                                 + pre_pkg::sx32(i_point_y_base), EffW);
        s_z   = pre_pkg::sat_val(pre_pkg::sx32(i_point_z_delta)
                                 + pre_pkg::sx32(i_point_z_base), EffW);
        n_cmd.op     = pre_pkg::t_op'(i_opcode);
        n_cmd.idx    = i_entry_index;
        n_cmd.a0     = (n_cmd.op == pre_pkg::OP_LOAD) ? s_cam[31:0] : s_x[31:0];
        n_cmd.a1     = s_y[31:0];
        n_cmd.a2     = s_z[31:0];
        n_cmd.pt_sat = s_x[32] | s_y[32] | s_z[32];
        n_cmd.obs_x  = i_observed_x;
        n_cmd.obs_y  = i_observed_y;
        // drop loads aimed past the last matrix entry
        keep = (n_cmd.op == pre_pkg::OP_PROJ)
               || (i_entry_index < pre_pkg::IDX_W'(pre_pkg::ENTRIES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (!i_cmd_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ sv/pre_div.sv @@
// ----------------------------------------------------------------------------
// pre_div
// Two restoring dividers sharing one divisor, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pre_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pre_pkg::NUM_W-1:0] i_num_x,
    input  logic [pre_pkg::NUM_W-1:0] i_num_y,
    input  logic [pre_pkg::DATA_W-1:0] i_den,
    output logic                      o_done,
    output logic [pre_pkg::NUM_W-1:0] o_quo_x,
    output logic [pre_pkg::NUM_W-1:0] o_quo_y
);

    localparam int NW    = pre_pkg::NUM_W;
    localparam int DW    = pre_pkg::DATA_W;
    localparam int RW    = DW + 1;
    localparam int STEPS = 2;
    localparam int ITER  = NW / STEPS;
    localparam int CNTW  = $clog2(ITER);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_den;
    logic [RW-1:0]   r_rem_x;
    logic [RW-1:0]   r_rem_y;
    logic [NW-1:0]   r_quo_x;
    logic [NW-1:0]   r_quo_y;
    logic [RW-1:0]   n_rem_x;
    logic [RW-1:0]   n_rem_y;
    logic [NW-1:0]   n_quo_x;
    logic [NW-1:0]   n_quo_y;

    assign o_done  = r_done;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;

    always_comb begin
        n_rem_x = r_rem_x;
        n_rem_y = r_rem_y;
        n_quo_x = r_quo_x;
        n_quo_y = r_quo_y;
        for (int s = 0; s < STEPS; s++) begin
            n_rem_x = {n_rem_x[DW-1:0], n_quo_x[NW-1]};
            n_quo_x = {n_quo_x[NW-2:0], 1'b0};
            if (n_rem_x >= {1'b0, r_den}) begin
                n_rem_x    = n_rem_x - {1'b0, r_den};
                n_quo_x[0] = 1'b1;
            end
            n_rem_y = {n_rem_y[DW-1:0], n_quo_y[NW-1]};
            n_quo_y = {n_quo_y[NW-2:0], 1'b0};
            if (n_rem_y >= {1'b0, r_den}) begin
                n_rem_y    = n_rem_y - {1'b0, r_den};
                n_quo_y[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den   <= i_den;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_quo_x <= i_num_x;
            r_quo_y <= i_num_y;
        end else if (r_busy) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_quo_x <= n_quo_x;
            r_quo_y <= n_quo_y;
        end
    end

endmodule

@@ sv/pre_back.sv @@
// ----------------------------------------------------------------------------
// pre_back
// Holds the camera matrix and runs loads and projections on one multiplier.
// ----------------------------------------------------------------------------
`include "projective_reprojection_error_macros.svh"

module pre_back #(
    parameter int VALUE_WIDTH = pre_pkg::VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  pre_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_push,
    output pre_pkg::t_res o_res,
    input  logic          i_res_full
);

    localparam int EffW = pre_pkg::eff_width(VALUE_WIDTH);
    localparam int DW   = pre_pkg::DATA_W;
    localparam int AW   = pre_pkg::ACC_W;
    localparam int NW   = pre_pkg::NUM_W;
    localparam int IW   = pre_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_ROW, S_CHK, S_DIVW, S_QSAT, S_RES, S_OUT
    } t_state;

    t_state               r_state;
    pre_pkg::t_cmd        r_cmd;
    logic signed [DW-1:0] r_cam [pre_pkg::ENTRIES];
    logic [1:0]           r_row;
    logic [1:0]           r_cnt;
    logic [DW-1:0]        r_tr;
    logic signed [2*DW-1:0] r_prod;
    logic                 r_pvld;
    logic signed [AW-1:0] r_acc;
    logic [DW-1:0]        r_rows [3];
    logic                 r_sat;
    logic [DW-1:0]        r_qx;
    logic [DW-1:0]        r_qy;
    pre_pkg::t_res        r_res;

    logic [IW-1:0]        rd_addr;
    logic signed [DW-1:0] cam_rd;
    logic signed [DW-1:0] pt_op;
    logic [DW:0]          row_s;
    logic [DW-1:0]        abs_x;
    logic [DW-1:0]        abs_y;
    logic [DW-1:0]        abs_z;
    logic                 div_start;
    logic                 div_done;
    logic [NW-1:0]        quo_x;
    logic [NW-1:0]        quo_y;
    logic signed [NW:0]   sq_x;
    logic signed [NW:0]   sq_y;
    logic [DW:0]          qs_x;
    logic [DW:0]          qs_y;
    logic [DW:0]          rs_x;
    logic [DW:0]          rs_y;

    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;
    assign o_res      = r_res;
    assign div_start  = (r_state == S_CHK) && (r_rows[2] != '0);

    always_comb begin
        case (r_cnt)
            2'd0:    rd_addr = IW'(9) + IW'(r_row);
            2'd1:    rd_addr = IW'(r_row);
            2'd2:    rd_addr = IW'(3) + IW'(r_row);
            default: rd_addr = IW'(6) + IW'(r_row);
        endcase
        case (r_cnt)
            2'd2:    pt_op = r_cmd.a1;
            2'd3:    pt_op = r_cmd.a2;
            default: pt_op = r_cmd.a0;
        endcase
        cam_rd = r_cam[rd_addr];
        row_s  = pre_pkg::sat_val(pre_pkg::sx32(r_tr) + (r_acc >>> pre_pkg::FRAC), EffW);
        abs_x  = r_rows[0][DW-1] ? -r_rows[0] : r_rows[0];
        abs_y  = r_rows[1][DW-1] ? -r_rows[1] : r_rows[1];
        abs_z  = r_rows[2][DW-1] ? -r_rows[2] : r_rows[2];
        sq_x   = (r_rows[0][DW-1] ^ r_rows[2][DW-1]) ? -signed'({1'b0, quo_x})
                                                       : signed'({1'b0, quo_x});
        sq_y   = (r_rows[1][DW-1] ^ r_rows[2][DW-1]) ? -signed'({1'b0, quo_y})
                                                       : signed'({1'b0, quo_y});
        qs_x   = pre_pkg::sat_val(AW'(sq_x), EffW);
        qs_y   = pre_pkg::sat_val(AW'(sq_y), EffW);
        rs_x   = pre_pkg::sat_val(pre_pkg::sx32(r_qx) - pre_pkg::sx32(r_cmd.obs_x), EffW);
        rs_y   = pre_pkg::sat_val(pre_pkg::sx32(r_qy) - pre_pkg::sx32(r_cmd.obs_y), EffW);
    end

    pre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_x ({abs_x, {pre_pkg::FRAC{1'b0}}}),
        .i_num_y ({abs_y, {pre_pkg::FRAC{1'b0}}}),
        .i_den   (abs_z),
        .o_done  (div_done),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pvld  <= 1'b0;
            for (int e = 0; e < pre_pkg::ENTRIES; e++) begin
                r_cam[e] <= '0;
            end
        end else begin
            if (r_pvld) begin
                r_acc <= r_acc + AW'(r_prod);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        if (i_cmd.op == pre_pkg::OP_LOAD) begin
                            if (i_cmd.idx < IW'(pre_pkg::ENTRIES)) begin
                                r_cam[i_cmd.idx] <= i_cmd.a0;
                            end
                        end else begin
                            r_cmd   <= i_cmd;
                            r_sat   <= i_cmd.pt_sat;
                            r_row   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_cnt == 2'd0) begin
                        r_tr  <= cam_rd;
                        r_acc <= '0;
                    end else begin
                        r_prod <= cam_rd * pt_op;
                        r_pvld <= 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_pvld  <= 1'b0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_rows[r_row] <= row_s[DW-1:0];
                    r_sat         <= r_sat | row_s[DW];
                    if (r_row == 2'd2) begin
                        r_state <= S_CHK;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_CHK: begin
                    if (r_rows[2] == '0) begin
                        r_res.rx     <= '0;
                        r_res.ry     <= '0;
                        r_res.status <= pre_pkg::ST_ZERO_DEPTH;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= S_QSAT;
                    end
                end
                S_QSAT: begin
                    r_qx    <= qs_x[DW-1:0];
                    r_qy    <= qs_y[DW-1:0];
                    r_sat   <= r_sat | qs_x[DW] | qs_y[DW];
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_res.rx     <= rs_x[DW-1:0];
                    r_res.ry     <= rs_y[DW-1:0];
                    r_res.status <= (r_sat | rs_x[DW] | rs_y[DW]) ? pre_pkg::ST_SAT
                                                                  : pre_pkg::ST_OK;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PRE_ASSERT(a_pvld_state, i_clk, i_rst_n, !r_pvld || r_state == S_MUL || r_state == S_SUM)
    `PRE_ASSERT(a_div_state, i_clk, i_rst_n, !div_done || r_state == S_DIVW)
    `PRE_ASSERT_NEXT(a_zero_depth, i_clk, i_rst_n, r_state == S_CHK && r_rows[2] == '0, r_res.status == pre_pkg::ST_ZERO_DEPTH)

endmodule

@@ sv/projective_reprojection_error.sv @@
// ----------------------------------------------------------------------------
// projective_reprojection_error
// Camera matrix store and point projection with saturated residuals.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake         payload
//  request   in         push / full       i_opcode, i_entry_index, camera and
//                                          point delta/base, observed pixel
//  result    out        empty / pop       o_residual_x, o_residual_y, o_status
//
//  A load request yields no result.
//  A project request runs three rows on the shared 32x32 multiplier (each a
//  translation read plus three products), then, for a nonzero depth, the
//  two-bit-per-cycle divider, then saturation and handoff.
//  Reset (synchronous, active low) clears the matrix and all queues at once.
//  Two-entry queues sit between front and back and at the result side, so
//  requests keep arriving while a finished result waits for pop.
//
module projective_reprojection_error #(
    parameter int VALUE_WIDTH = pre_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_camera_delta,
    input  logic [31:0] i_camera_base,
    input  logic [31:0] i_point_x_delta,
    input  logic [31:0] i_point_y_delta,
    input  logic [31:0] i_point_z_delta,
    input  logic [31:0] i_point_x_base,
    input  logic [31:0] i_point_y_base,
    input  logic [31:0] i_point_z_base,
    input  logic [31:0] i_observed_x,
    input  logic [31:0] i_observed_y,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_residual_x,
    output logic [31:0] o_residual_y,
    output logic [1:0]  o_status
);

    localparam int CmdW = $bits(pre_pkg::t_cmd);
    localparam int ResW = $bits(pre_pkg::t_res);

    // front -> command queue
    logic          fr_push;
    pre_pkg::t_cmd fr_cmd;
    logic          cq_full;
    // command queue -> back
    logic          cq_empty;
    logic [CmdW-1:0] cq_data;
    logic          bk_pop;
    // back -> result queue
    logic          bk_push;
    pre_pkg::t_res bk_res;
    logic          rq_full;
    logic [ResW-1:0] rq_data;
    pre_pkg::t_res res_head;

    // Front: accept requests, form saturated sums, drop out-of-range loads.
    pre_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_entry_index   (i_entry_index),
        .i_camera_delta  (i_camera_delta),
        .i_camera_base   (i_camera_base),
        .i_point_x_delta (i_point_x_delta),
        .i_point_y_delta (i_point_y_delta),
        .i_point_z_delta (i_point_z_delta),
        .i_point_x_base  (i_point_x_base),
        .i_point_y_base  (i_point_y_base),
        .i_point_z_base  (i_point_z_base),
        .i_observed_x    (i_observed_x),
        .i_observed_y    (i_observed_y),
        .o_cmd_push      (fr_push),
        .o_cmd           (fr_cmd),
        .i_cmd_full      (cq_full)
    );

    // Hold classified work so the front keeps taking requests while the
    // back grinds through a projection.
    pre_queue #(
        .W     (CmdW),
        .DEPTH (pre_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_cmd),
        .o_full  (cq_full),
        .i_pop   (bk_pop),
        .o_data  (cq_data),
        .o_empty (cq_empty)
    );

    // Back: apply loads in order, run projections on the shared units.
    pre_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cq_empty),
        .i_cmd       (pre_pkg::t_cmd'(cq_data)),
        .o_cmd_pop   (bk_pop),
        .o_res_push  (bk_push),
        .o_res       (bk_res),
        .i_res_full  (rq_full)
    );

    // Result queue: the oldest result stays on the ports until popped.
    pre_queue #(
        .W     (ResW),
        .DEPTH (pre_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_push),
        .i_data  (bk_res),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_data),
        .o_empty (empty)
    );

    assign res_head     = pre_pkg::t_res'(rq_data);
    assign o_residual_x = res_head.rx;
    assign o_residual_y = res_head.ry;
    assign o_status     = res_head.status;

endmodule
